### src/m4vt_pkg.sv
`timescale 1ns / 1ps

package m4vt_pkg;

  localparam int LANES       = 4;
  localparam int LANE_BITS   = 16;
  localparam int ROW_BITS    = LANES * LANE_BITS;
  localparam int FRAC_SHIFT  = 12;
  localparam int OUT_W       = 32;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_COEF_WIDTH  = 16;
  localparam int DEF_COORD_WIDTH = 32;

  // 1.0 in Q4.12 and in Q16.16
  localparam logic [LANE_BITS-1:0] COEF_ONE = 16'h1000;
  localparam int ONE_Q16 = 65536;
  // narrowest signed width that holds ONE_Q16
  localparam int ONE_Q16_W = 18;

  localparam logic [KIND_W-1:0] KIND_POSITION  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIRECTION = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW3 = 2'd3;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [ROW_BITS-1:0]    data;
  } cfg_wr_t;

endpackage

### src/m4vt_coef_regs.sv
`timescale 1ns / 1ps

module m4vt_coef_regs #(
  parameter int COEF_WIDTH = m4vt_pkg::DEF_COEF_WIDTH
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  m4vt_pkg::cfg_wr_t                               wr,
  output logic [m4vt_pkg::LANES-1:0][m4vt_pkg::LANES-1:0][COEF_WIDTH-1:0] coef
);
  import m4vt_pkg::*;

  localparam logic [COEF_WIDTH-1:0] ONE = COEF_ONE[COEF_WIDTH-1:0];

  logic [LANES-1:0][COEF_WIDTH-1:0] row_new;

  // only the low COEF_WIDTH bits of each lane are kept
  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      row_new[c] = wr.data[c*LANE_BITS +: COEF_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < LANES; r++) begin
        for (int c = 0; c < LANES; c++) begin
          coef[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (wr.en) begin
      unique case (wr.index)
        REG_ROW0: coef[0] <= row_new;
        REG_ROW1: coef[1] <= row_new;
        REG_ROW2: coef[2] <= row_new;
        REG_ROW3: coef[3] <= row_new;
        default:  coef[0] <= coef[0];
      endcase
    end
  end

endmodule

### src/m4vt_row_mul.sv
`timescale 1ns / 1ps

module m4vt_row_mul #(
  parameter int COEF_WIDTH = m4vt_pkg::DEF_COEF_WIDTH,
  parameter int VEC_W      = m4vt_pkg::DEF_COORD_WIDTH,
  parameter int PROD_W     = COEF_WIDTH + VEC_W
) (
  input  logic                                       clk,
  input  logic                                       load,
  input  logic [m4vt_pkg::LANES-1:0][COEF_WIDTH-1:0] coef,
  input  logic [m4vt_pkg::LANES-1:0][VEC_W-1:0]      vec,
  output logic [m4vt_pkg::LANES-1:0][PROD_W-1:0]     prod
);
  import m4vt_pkg::*;

  logic signed [COEF_WIDTH-1:0] a [LANES];
  logic signed [VEC_W-1:0]      b [LANES];

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      a[c] = coef[c];
      b[c] = vec[c];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < LANES; c++) begin
        prod[c] <= a[c] * b[c];
      end
    end
  end

endmodule

### src/m4vt_row_sum.sv
`timescale 1ns / 1ps

module m4vt_row_sum #(
  parameter int PROD_W = m4vt_pkg::DEF_COEF_WIDTH + m4vt_pkg::DEF_COORD_WIDTH
) (
  input  logic [m4vt_pkg::LANES-1:0][PROD_W-1:0] prod,
  output logic [m4vt_pkg::OUT_W-1:0]             result,
  output logic                                   clip
);
  import m4vt_pkg::*;

  localparam int SUM_W = PROD_W + 2;
  localparam int SH_W  = SUM_W - FRAC_SHIFT;
  localparam int EXT_W = (SH_W > OUT_W) ? SH_W : OUT_W + 1;

  localparam logic signed [EXT_W-1:0] SAT_HI = {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO = {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [PROD_W-1:0] p [LANES];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;
  logic signed [EXT_W-1:0]  ext;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      p[c] = prod[c];
    end
    sum = SUM_W'(p[0]) + SUM_W'(p[1]) + SUM_W'(p[2]) + SUM_W'(p[3]);
    // dropping the fraction bits of a two's complement value rounds toward minus infinity
    sh  = sum[SUM_W-1:FRAC_SHIFT];
    ext = EXT_W'(sh);
    if (ext > SAT_HI) begin
      result = SAT_HI[OUT_W-1:0];
      clip   = 1'b1;
    end else if (ext < SAT_LO) begin
      result = SAT_LO[OUT_W-1:0];
      clip   = 1'b1;
    end else begin
      result = ext[OUT_W-1:0];
      clip   = 1'b0;
    end
  end

endmodule

### src/mat4_vertex_transform.sv
`timescale 1ns / 1ps

// Homogeneous 4x4 matrix times vertex, Q4.12 matrix, Q16.16 coordinates.
// Matrix: cfg channel (cfg_valid/cfg_ready, cfg_index 0..3 selects a row,
//   cfg_data holds four 16-bit lanes, column 0 in the low lane). cfg_ready is
//   always high; a row is written in the cycle of its beat. Write rows only
//   while no vertex is in flight.
// Vertex channel: vtx_valid/vtx_stall with kind and in_x..in_w. kind 0 uses
//   w = 1.0, kind 1 uses w = 0, kind 2 (and 3) use in_w.
// Result channel: res_valid/res_stall with out_x..out_w and saturated, which
//   is set when any of the four row sums was clipped to 32 bits.
// Pipeline: input register, product register (16 multipliers), result
//   register; a vertex beat passes through them in that order to res_valid.
//   One vertex per cycle sustained while res_stall is low; the three stages
//   fill completely before res_stall pushes back to vtx_stall.
// Reset empties the pipeline and loads the identity matrix.
module mat4_vertex_transform #(
  parameter int COEF_WIDTH  = m4vt_pkg::DEF_COEF_WIDTH,
  parameter int COORD_WIDTH = m4vt_pkg::DEF_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [m4vt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [m4vt_pkg::ROW_BITS-1:0]      cfg_data,

  input  logic                               vtx_valid,
  output logic                               vtx_stall,
  input  logic [m4vt_pkg::KIND_W-1:0]        kind,
  input  logic signed [31:0]                 in_x,
  input  logic signed [31:0]                 in_y,
  input  logic signed [31:0]                 in_z,
  input  logic signed [31:0]                 in_w,

  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [m4vt_pkg::OUT_W-1:0]  out_x,
  output logic signed [m4vt_pkg::OUT_W-1:0]  out_y,
  output logic signed [m4vt_pkg::OUT_W-1:0]  out_z,
  output logic signed [m4vt_pkg::OUT_W-1:0]  out_w,
  output logic                               saturated
);
  import m4vt_pkg::*;

  localparam int VEC_W  = (COORD_WIDTH > ONE_Q16_W) ? COORD_WIDTH : ONE_Q16_W;
  localparam int PROD_W = COEF_WIDTH + VEC_W;

  cfg_wr_t cfg_wr;
  logic [LANES-1:0][LANES-1:0][COEF_WIDTH-1:0] coef;

  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready, s3_ready;
  logic vtx_accept;

  logic signed [COORD_WIDTH-1:0] x_lo, y_lo, z_lo, w_lo;
  logic [LANES-1:0][VEC_W-1:0] vec_next;
  logic [LANES-1:0][VEC_W-1:0] vec;

  logic [LANES-1:0][LANES-1:0][PROD_W-1:0] prod;
  logic [LANES-1:0][OUT_W-1:0] row_res;
  logic [LANES-1:0] row_clip;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid & cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  m4vt_coef_regs #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg_wr),
    .coef (coef)
  );

  // backpressure ripples back only through stages that hold a beat
  assign s3_ready   = !res_valid || !res_stall;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign vtx_stall  = !s1_ready;
  assign vtx_accept = vtx_valid && s1_ready;

  assign x_lo = in_x[COORD_WIDTH-1:0];
  assign y_lo = in_y[COORD_WIDTH-1:0];
  assign z_lo = in_z[COORD_WIDTH-1:0];
  assign w_lo = in_w[COORD_WIDTH-1:0];

  always_comb begin
    vec_next[0] = VEC_W'(x_lo);
    vec_next[1] = VEC_W'(y_lo);
    vec_next[2] = VEC_W'(z_lo);
    case (kind)
      KIND_POSITION:  vec_next[3] = VEC_W'(ONE_Q16);
      KIND_DIRECTION: vec_next[3] = '0;
      default:        vec_next[3] = VEC_W'(w_lo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= vtx_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        res_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_accept) begin
      vec <= vec_next;
    end
  end

  for (genvar r = 0; r < LANES; r++) begin : g_row
    m4vt_row_mul #(
      .COEF_WIDTH (COEF_WIDTH),
      .VEC_W      (VEC_W),
      .PROD_W     (PROD_W)
    ) u_mul (
      .clk  (clk),
      .load (s1_valid && s2_ready),
      .coef (coef[r]),
      .vec  (vec),
      .prod (prod[r])
    );

    m4vt_row_sum #(
      .PROD_W (PROD_W)
    ) u_sum (
      .prod   (prod[r]),
      .result (row_res[r]),
      .clip   (row_clip[r])
    );
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      out_x     <= row_res[0];
      out_y     <= row_res[1];
      out_z     <= row_res[2];
      out_w     <= row_res[3];
      saturated <= |row_clip;
    end
  end

endmodule

### src/m4vt_checker.sv
`timescale 1ns / 1ps

module m4vt_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_ready,
  input logic               vtx_valid,
  input logic               vtx_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic signed [31:0] out_w,
  input logic               saturated
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
      && $stable(out_w) && $stable(saturated))
    else $error("stalled result changed");

  // a clipped beat has at least one lane pinned to a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |->
      out_x == 32'sh7fffffff || out_x == 32'sh80000000 ||
      out_y == 32'sh7fffffff || out_y == 32'sh80000000 ||
      out_z == 32'sh7fffffff || out_z == 32'sh80000000 ||
      out_w == 32'sh7fffffff || out_w == 32'sh80000000)
    else $error("saturated set with no lane at a rail");

  // input stalls only when a full pipeline meets a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> res_valid && res_stall && cfg_ready)
    else $error("vertex stall without output backpressure");

endmodule

bind mat4_vertex_transform m4vt_checker u_m4vt_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .vtx_valid (vtx_valid),
  .vtx_stall (vtx_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .out_w     (out_w),
  .saturated (saturated)
);

### verif/mat4_vertex_transform_test.sv
`timescale 1ns / 1ps

module mat4_vertex_transform_test;
  import m4vt_pkg::*;

  // kind 3 has no name in the package; the block decodes it as a full vector
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 180;

  typedef logic signed [OUT_W-1:0] coord_t;

  localparam coord_t Q_TOP    = 32'sh7FFF_FFFF;
  localparam coord_t Q_BOTTOM = 32'sh8000_0000;
  localparam coord_t Q_ONE    = 32'sh0001_0000;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  localparam logic [ROW_BITS-1:0] ROW_POS_MAX = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [ROW_BITS-1:0] ROW_NEG_MAX = 64'h8000_8000_8000_8000;
  localparam logic [ROW_BITS-1:0] ROW_NEG_LSB = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ROW_BITS-1:0] ROW_MIXED   = 64'h7FFF_8000_7FFF_8000;
  localparam logic [ROW_BITS-1:0] ROW_POS_LSB = 64'h0001_0001_0001_0001;

  typedef struct {
    coord_t v[LANES];
    logic   sat;
  } xform_t;

  class xform_scoreboard;
    logic [ROW_BITS-1:0] matrix[LANES];
    xform_t              expected_q[$];
    int                  errors;

    function new();
      for (int r = 0; r < LANES; r++) begin
        matrix[r] = ROW_BITS'(COEF_ONE) << (r * LANE_BITS);
      end
      errors = 0;
    endfunction

    function void load_row(logic [CFG_INDEX_W-1:0] idx, logic [ROW_BITS-1:0] data);
      matrix[idx] = data;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_vertex(logic [KIND_W-1:0] k, coord_t x, coord_t y, coord_t z,
                              coord_t w);
      longint                      vec[LANES];
      longint                      acc;
      logic signed [LANE_BITS-1:0] cf;
      xform_t                      e;
      vec[0] = longint'(x);
      vec[1] = longint'(y);
      vec[2] = longint'(z);
      if (k[1]) begin
        vec[3] = longint'(w);
      end else if (k == KIND_DIRECTION) begin
        vec[3] = '0;
      end else begin
        vec[3] = longint'(ONE_Q16);
      end
      e.sat = 1'b0;
      for (int r = 0; r < LANES; r++) begin
        acc = 0;
        for (int c = 0; c < LANES; c++) begin
          cf = matrix[r][c*LANE_BITS +: LANE_BITS];
          acc += longint'(cf) * vec[c];
        end
        acc = acc >>> FRAC_SHIFT;  // floor
        if (acc > SUM_MAX) begin
          e.v[r] = Q_TOP;
          e.sat  = 1'b1;
        end else if (acc < SUM_MIN) begin
          e.v[r] = Q_BOTTOM;
          e.sat  = 1'b1;
        end else begin
          e.v[r] = coord_t'(acc);
        end
      end
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(coord_t x, coord_t y, coord_t z, coord_t w, logic sat);
      xform_t e;
      coord_t got[LANES];
      got = '{x, y, z, w};
      if (expected_q.size() == 0) begin
        report("result beat with no vertex outstanding");
        return;
      end
      e = expected_q.pop_front();
      for (int r = 0; r < LANES; r++) begin
        if (got[r] !== e.v[r]) begin
          report($sformatf("row %0d: got %h, expected %h", r, got[r], e.v[r]));
        end
      end
      if (sat !== e.sat) report($sformatf("saturated: got %b, expected %b", sat, e.sat));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [ROW_BITS-1:0]    cfg_data;
  logic                   vtx_valid;
  logic                   vtx_stall;
  logic [KIND_W-1:0]      kind;
  coord_t                 in_x, in_y, in_z, in_w;
  logic                   res_valid;
  logic                   res_stall;
  coord_t                 out_x, out_y, out_z, out_w;
  logic                   saturated;

  xform_scoreboard sb = new();

  int cycles = 0;
  int vtx_idle_pct;
  int stall_pct;
  int stall_left;

  mat4_vertex_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .kind      (kind),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_w      (in_w),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mat4_vertex_transform regression: fail");
      $finish;
    end
  end

  // beats are observed at the rising edge, before the block's registers move
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.load_row(cfg_index, cfg_data);
      if (vtx_valid && !vtx_stall) sb.note_vertex(kind, in_x, in_y, in_z, in_w);
      if (res_valid && !res_stall) sb.check_result(out_x, out_y, out_z, out_w, saturated);
    end
  end

  // result back-pressure: mostly short bursts, now and then a long one
  always @(negedge clk) begin
    if (rst) begin
      res_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall = 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      res_stall  = 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      res_stall = 1'b0;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= vtx_idle_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4)) inside
      0, 1: return $urandom;
      2: return coord_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: return Q_TOP;
          1: return Q_BOTTOM;
          2: return '0;
          3: return -1;
          default: return Q_ONE;
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 64)) - 32) <<< 16;
    endcase
  endfunction

  function automatic logic [ROW_BITS-1:0] rand_row();
    logic [ROW_BITS-1:0] row;
    logic [LANE_BITS-1:0] cf;
    for (int c = 0; c < LANES; c++) begin
      case ($urandom_range(0, 3))
        0: cf = LANE_BITS'($urandom);
        1: cf = LANE_BITS'(int'($urandom_range(0, 16384)) - 8192);
        2: begin
          case ($urandom_range(0, 3))
            0: cf = 16'h7FFF;
            1: cf = 16'h8000;
            2: cf = 16'hFFFF;
            default: cf = 16'h0001;
          endcase
        end
        default: cf = $urandom_range(0, 1) ? COEF_ONE : '0;
      endcase
      row[c*LANE_BITS +: LANE_BITS] = cf;
    end
    return row;
  endfunction

  task automatic send_vertex(logic [KIND_W-1:0] k, coord_t x, coord_t y, coord_t z,
                             coord_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      vtx_valid = 1'b0;
      kind      = KIND_W'($urandom);
      in_x      = $urandom;
      in_y      = $urandom;
      in_z      = $urandom;
      in_w      = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    vtx_valid = 1'b1;
    kind      = k;
    in_x      = x;
    in_y      = y;
    in_z      = z;
    in_w      = w;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
  endtask

  task automatic write_row(logic [CFG_INDEX_W-1:0] idx, logic [ROW_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_matrix(logic [ROW_BITS-1:0] r0, logic [ROW_BITS-1:0] r1,
                              logic [ROW_BITS-1:0] r2, logic [ROW_BITS-1:0] r3);
    write_row(REG_ROW0, r0);
    write_row(REG_ROW1, r1);
    write_row(REG_ROW2, r2);
    write_row(REG_ROW3, r3);
  endtask

  // pipeline empty: every expected beat seen, plus a few cycles of slack
  task automatic settle();
    @(negedge clk);
    vtx_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int idle_tab[NUM_PHASES];
    int stall_tab[NUM_PHASES];
    idle_tab  = '{0, 25, 60, 10, 40, 5};
    stall_tab = '{0, 25, 10, 60, 40, 70};
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = REG_ROW0;
    cfg_data     = '0;
    vtx_valid    = 1'b0;
    kind         = KIND_POSITION;
    in_x         = '0;
    in_y         = '0;
    in_z         = '0;
    in_w         = '0;
    vtx_idle_pct = 20;
    stall_pct    = 20;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // identity matrix out of reset; in_w must be ignored unless kind selects it
    send_vertex(KIND_POSITION, 0, 0, 0, 0);
    send_vertex(KIND_POSITION, Q_TOP, Q_TOP, Q_TOP, Q_BOTTOM);
    send_vertex(KIND_DIRECTION, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_TOP);
    send_vertex(KIND_FULL, Q_TOP, Q_BOTTOM, -1, Q_TOP);
    send_vertex(KIND_SPARE, 1, -1, Q_ONE, Q_BOTTOM);
    send_vertex(KIND_FULL, -1, -1, -1, -1);
    settle();

    // largest positive coefficients: clip high and low
    write_matrix(ROW_POS_MAX, ROW_POS_MAX, ROW_POS_MAX, ROW_POS_MAX);
    send_vertex(KIND_FULL, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
    send_vertex(KIND_FULL, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);
    send_vertex(KIND_POSITION, Q_ONE, 0, 0, 0);
    send_vertex(KIND_DIRECTION, 1, 1, 1, 0);
    settle();

    // most negative, -1 LSB, mixed and +1 LSB coefficients: floor rounding of negative sums
    write_matrix(ROW_NEG_MAX, ROW_NEG_LSB, ROW_MIXED, ROW_POS_LSB);
    send_vertex(KIND_FULL, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
    send_vertex(KIND_FULL, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);
    send_vertex(KIND_DIRECTION, 1, 0, 0, 0);
    send_vertex(KIND_POSITION, 0, 0, 0, 0);
    send_vertex(KIND_SPARE, Q_BOTTOM, Q_TOP, Q_BOTTOM, Q_TOP);
    send_vertex(KIND_DIRECTION, -1, 0, 0, Q_TOP);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      vtx_idle_pct = idle_tab[ph];
      stall_pct    = stall_tab[ph];
      write_matrix(rand_row(), rand_row(), rand_row(), rand_row());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_vertex(KIND_W'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
      end
      settle();
    end

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("mat4_vertex_transform regression: pass");
    end else begin
      $display("mat4_vertex_transform regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/m4vt_pkg.sv
src/m4vt_coef_regs.sv
src/m4vt_row_mul.sv
src/m4vt_row_sum.sv
src/mat4_vertex_transform.sv
src/m4vt_checker.sv
verif/mat4_vertex_transform_test.sv
